// ===== design/rgba_unorm_to_half_float_top_macros.svh =====
// Assertion macros shared by the RTL of the unorm to half-float converter
`ifndef RGBA_UNORM_TO_HALF_FLOAT_TOP_MACROS_SVH
`define RGBA_UNORM_TO_HALF_FLOAT_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Check a condition on every clock edge out of reset
`define RUTF_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("rutf assertion failed");
// Check a consequent starting in the cycle after the antecedent
`define RUTF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("rutf assertion failed");
`else
`define RUTF_ASSERT_ALWAYS(lbl, cond)
`define RUTF_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== design/rutf_pkg.sv =====
// Types and constant scale table for the unorm to half-float converter
package rutf_pkg;

    typedef logic [31:0] f32_t;
    typedef logic [15:0] f16_t;
    typedef logic [15:0] sample_t;
    typedef logic [4:0]  depth_t;

    localparam depth_t DEPTH_MIN   = 5'd1;
    localparam depth_t DEPTH_MAX   = 5'd16;
    localparam depth_t DEPTH_RESET = 5'd10;

    // Binary32 of 1/(2^n - 1), round to nearest even; fraction bits repeat every n places
    function automatic f32_t scale_bits(int n);
        logic [22:0] frac;
        int k;
        frac = '0;
        if (n <= 1)
        begin
            return 32'h3F80_0000;
        end
        for (k = n; k <= 23; k += n)
        begin
            frac[23 - k] = 1'b1;
        end
        // Tail never ties; round up when the first dropped bit is set
        if (k == 24)
        begin
            frac = frac + 23'd1;
        end
        return {1'b0, 8'(127 - n), frac};
    endfunction

    localparam f32_t SCALE_TAB [17] = '{
        scale_bits(0),  scale_bits(1),  scale_bits(2),  scale_bits(3),
        scale_bits(4),  scale_bits(5),  scale_bits(6),  scale_bits(7),
        scale_bits(8),  scale_bits(9),  scale_bits(10), scale_bits(11),
        scale_bits(12), scale_bits(13), scale_bits(14), scale_bits(15),
        scale_bits(16)
    };

endpackage

// ===== design/rutf_lane.sv =====
// One channel lane: multiply by scale, round to binary32, round to binary16
module rutf_lane (
    input  logic           clk,
    input  rutf_pkg::sample_t sample,
    input  rutf_pkg::f32_t scale,
    output rutf_pkg::f16_t half
);
    import rutf_pkg::*;

    logic [39:0] prod_reg;
    logic [7:0]  sexp_reg;
    f32_t        f32_reg;
    f32_t        f32_next;

    logic [5:0]  lead;
    logic [39:0] norm;
    logic        rnd_up;
    logic [24:0] mant;
    logic [9:0]  exp_sum;

    // Binary32 to binary16, round to nearest even, subnormals kept
    function automatic f16_t to_half(f32_t f);
        logic [15:0] sgn;
        logic [7:0]  ex;
        logic [22:0] mn;
        logic signed [9:0] he;
        logic [14:0] res;
        logic [12:0] rem_n;
        logic [9:0]  sh_w;
        logic [4:0]  sh;
        logic [23:0] m;
        logic [23:0] q;
        logic [23:0] rem_s;
        logic [23:0] halfway;
        sgn   = {f[31], 15'd0};
        ex    = f[30:23];
        mn    = f[22:0];
        he    = signed'({2'b00, ex}) - 10'sd112;
        res   = '0;
        rem_n = mn[12:0];
        sh_w  = '0;
        sh    = '0;
        m     = {1'b1, mn};
        q     = '0;
        rem_s = '0;
        halfway = '0;
        if (ex == 8'hFF)
        begin
            return sgn | 16'h7C00 | ((mn != 23'd0) ? 16'h0200 : 16'h0000);
        end
        if (ex == 8'h00)
        begin
            return sgn;
        end
        if (he >= 10'sd31)
        begin
            return sgn | 16'h7C00;
        end
        if (he >= 10'sd1)
        begin
            res = {he[4:0], mn[22:13]};
            if (rem_n > 13'h1000 || (rem_n == 13'h1000 && res[0]))
            begin
                res = res + 15'd1;
            end
            return sgn | {1'b0, res};
        end
        sh_w = 10'(10'sd14 - he);
        if (sh_w > 10'd24)
        begin
            return sgn;
        end
        sh      = sh_w[4:0];
        q       = m >> sh;
        rem_s   = m & ((24'd1 << sh) - 24'd1);
        halfway = 24'd1 << (sh - 5'd1);
        if (rem_s > halfway || (rem_s == halfway && q[0]))
        begin
            q = q + 24'd1;
        end
        return sgn | q[15:0];
    endfunction

    // Hold the exact product and the scale exponent
    always_ff @(posedge clk)
    begin
        prod_reg <= {24'd0, sample} * {16'd0, 1'b1, scale[22:0]};
        sexp_reg <= scale[30:23];
    end

    // Find the leading one and round the product to 24 significant bits
    always_comb
    begin
        lead = '0;
        for (int i = 0; i < 40; i++)
        begin
            if (prod_reg[i])
            begin
                lead = 6'(i);
            end
        end
        norm    = prod_reg << (6'd39 - lead);
        rnd_up  = norm[15] & ((|norm[14:0]) | norm[16]);
        mant    = {1'b0, norm[39:16]} + 25'(rnd_up);
        exp_sum = {4'd0, lead} + {2'd0, sexp_reg} - 10'd23 + 10'(mant[24]);
        if (prod_reg == 40'd0)
        begin
            f32_next = '0;
        end
        else
        begin
            f32_next = {1'b0, exp_sum[7:0], mant[22:0]};
        end
    end

    // Hold the rounded binary32 value
    always_ff @(posedge clk)
    begin
        f32_reg <= f32_next;
    end

    assign half = to_half(f32_reg);

endmodule

// ===== design/rgba_unorm_to_half_float_top.sv =====
// Top level of the RGBA unorm16 to binary16 pixel converter
//
// channel   | handshake           | payload
// ----------+---------------------+-------------------------------------------
// pixel in  | start, busy         | red_in, green_in, blue_in, alpha_in
// pixel out | done (strobe)       | red_half, green_half, blue_half, alpha_half
// config    | cfg_wr_en           | cfg_wr_data (bit depth)
//
// One pixel per clock; each pixel's result strobes on done after its transfer
// has passed the product stage, binary32 rounding stage and merge register.
// busy stays low: four lanes run in a fixed pipeline with no stall points.
// Reset sets the bit depth to ten; the scale is looked up at config write.
// The receiver cannot stall; each result is shown for one cycle only.
module rgba_unorm_to_half_float_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rutf_pkg::sample_t    red_in,
    input  rutf_pkg::sample_t    green_in,
    input  rutf_pkg::sample_t    blue_in,
    input  rutf_pkg::sample_t    alpha_in,
    input  logic                 cfg_wr_en,
    input  rutf_pkg::depth_t     cfg_wr_data,
    output logic                 done,
    output rutf_pkg::f16_t       red_half,
    output rutf_pkg::f16_t       green_half,
    output rutf_pkg::f16_t       blue_half,
    output rutf_pkg::f16_t       alpha_half
);
    import rutf_pkg::*;
    `include "rgba_unorm_to_half_float_top_macros.svh"

    f32_t   scale_reg;
    f32_t   scale_next;
    depth_t depth_clamp;
    logic   v1_reg;
    logic   v2_reg;
    logic   done_reg;
    f16_t   lane_half [4];
    f16_t   half_reg  [4];
    sample_t lane_in  [4];

    assign busy = 1'b0;

    // Clamp the bit depth and look up its scale
    always_comb
    begin
        depth_clamp = cfg_wr_data;
        if (cfg_wr_data < DEPTH_MIN)
        begin
            depth_clamp = DEPTH_MIN;
        end
        else if (cfg_wr_data > DEPTH_MAX)
        begin
            depth_clamp = DEPTH_MAX;
        end
        scale_next = SCALE_TAB[depth_clamp];
    end

    // Hold the scale; load it on a config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_TAB[DEPTH_RESET];
        end
        else if (cfg_wr_en)
        begin
            scale_reg <= scale_next;
        end
    end

    // Advance the transfer marks along the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= start;
            v2_reg   <= v1_reg;
            done_reg <= v2_reg;
        end
    end

    assign lane_in[0] = red_in;
    assign lane_in[1] = green_in;
    assign lane_in[2] = blue_in;
    assign lane_in[3] = alpha_in;

    // Run one lane per channel
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        rutf_lane u_lane (
            .clk    (clk),
            .sample (lane_in[g]),
            .scale  (scale_reg),
            .half   (lane_half[g])
        );
    end

    // Merge the four lane results into the output register
    always_ff @(posedge clk)
    begin
        if (v2_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                half_reg[i] <= lane_half[i];
            end
        end
    end

    assign done       = done_reg;
    assign red_half   = half_reg[0];
    assign green_half = half_reg[1];
    assign blue_half  = half_reg[2];
    assign alpha_half = half_reg[3];

    `RUTF_ASSERT_NEXT(a_latency, start, ##2 done)
    `RUTF_ASSERT_NEXT(a_zero_red, start && red_in == 16'd0, ##2 red_half == 16'd0)
    `RUTF_ASSERT_NEXT(a_scale_hold, !cfg_wr_en, $stable(scale_reg))

endmodule

// ===== bench/tb.sv =====
// Testbench for the RGBA unorm16 to binary16 pixel converter
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rutf_pkg::*;

    typedef struct packed {
        f16_t r;
        f16_t g;
        f16_t b;
        f16_t a;
    } pixel_half_t;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    sample_t red_in;
    sample_t green_in;
    sample_t blue_in;
    sample_t alpha_in;
    logic    cfg_wr_en;
    depth_t  cfg_wr_data;
    logic    done;
    f16_t    red_half;
    f16_t    green_half;
    f16_t    blue_half;
    f16_t    alpha_half;

    pixel_half_t expected_pixels[$];
    depth_t      model_depth;
    int          mismatch_count;
    int          orphan_count;

    rgba_unorm_to_half_float_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .alpha_in   (alpha_in),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .done       (done),
        .red_half   (red_half),
        .green_half (green_half),
        .blue_half  (blue_half),
        .alpha_half (alpha_half)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // Shift right with round to nearest even
    function automatic logic [63:0] shift_rne(logic [63:0] v, int sh);
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        if (sh <= 0)
        begin
            return v;
        end
        q = v >> sh;
        rem = v & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

    // Binary32 bits to binary16 bits, round to nearest even, subnormals kept
    function automatic f16_t narrow_to_half(f32_t f);
        logic [7:0]  ex;
        logic [22:0] man;
        int          he;
        logic [63:0] res;
        ex = f[30:23];
        man = f[22:0];
        if (ex == 8'hFF)
        begin
            return {f[31], 5'h1F, (man != 0) ? 10'h200 : 10'h000};
        end
        if (ex == 8'h00)
        begin
            return {f[31], 15'h0};
        end
        he = int'(ex) - 127 + 15;
        if (he >= 31)
        begin
            return {f[31], 15'h7C00};
        end
        if (he >= 1)
        begin
            res = (64'(he) << 10) | 64'(man >> 13);
            if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && res[0]))
            begin
                res = res + 64'd1;
            end
            return {f[31], res[14:0]};
        end
        if (14 - he > 24)
        begin
            return {f[31], 15'h0};
        end
        res = shift_rne(64'({1'b1, man}), 14 - he);
        return {f[31], res[14:0]};
    endfunction

    // Scale one sample by 1/(2^n - 1): binary32 scale, binary32 product, then half
    function automatic f16_t normalize_sample(sample_t s, depth_t depth);
        int          n;
        int          sc_exp;
        int          p_exp;
        int          msb;
        logic [63:0] den;
        logic [63:0] sc_man;
        logic [63:0] rem;
        logic [63:0] prod;
        n = int'(depth);
        if (n < 1)
        begin
            n = 1;
        end
        if (n > 16)
        begin
            n = 16;
        end
        if (s == 0)
        begin
            return 16'h0000;
        end
        // Scale mantissa is 24 bits with weight 2^(sc_exp - 23)
        if (n == 1)
        begin
            sc_man = 64'h80_0000;
            sc_exp = 0;
        end
        else
        begin
            den = (64'd1 << n) - 64'd1;
            sc_man = (64'd1 << (23 + n)) / den;
            rem = (64'd1 << (23 + n)) % den;
            sc_exp = -n;
            if (2 * rem > den || (2 * rem == den && sc_man[0]))
            begin
                sc_man = sc_man + 64'd1;
            end
            if (sc_man[24])
            begin
                sc_man = sc_man >> 1;
                sc_exp = sc_exp + 1;
            end
        end
        // Exact product, then round to 24 significant bits
        prod = 64'(s) * sc_man;
        msb = 0;
        for (int k = 0; k < 64; k++)
        begin
            if (prod[k])
            begin
                msb = k;
            end
        end
        p_exp = sc_exp - 23 + msb;
        prod = shift_rne(prod, msb - 23);
        if (msb < 23)
        begin
            prod = prod << (23 - msb);
        end
        if (prod[24])
        begin
            prod = prod >> 1;
            p_exp = p_exp + 1;
        end
        return narrow_to_half({1'b0, 8'(p_exp + 127), prod[22:0]});
    endfunction

    // Predict each transfer and track config writes
    always @(posedge clk)
    begin
        pixel_half_t px;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                px.r = normalize_sample(red_in, model_depth);
                px.g = normalize_sample(green_in, model_depth);
                px.b = normalize_sample(blue_in, model_depth);
                px.a = normalize_sample(alpha_in, model_depth);
                expected_pixels.push_back(px);
            end
            if (cfg_wr_en)
            begin
                model_depth = cfg_wr_data;
            end
        end
    end

    // Compare each result against the oldest prediction
    always @(posedge clk)
    begin
        pixel_half_t px;
        pixel_half_t got;
        if (rst_n && done)
        begin
            got = '{red_half, green_half, blue_half, alpha_half};
            if (expected_pixels.size() == 0)
            begin
                orphan_count++;
                $display("unexpected result %h", got);
            end
            else
            begin
                px = expected_pixels.pop_front();
                if (got !== px)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch: expected r=%h g=%h b=%h a=%h got r=%h g=%h b=%h a=%h",
                                 px.r, px.g, px.b, px.a,
                                 got.r, got.g, got.b, got.a);
                    end
                end
            end
        end
    end

    // Random gap: mostly none, some short, a few long
    function automatic int pick_gap();
        int sel;
        sel = $urandom_range(99);
        if (sel < 60)
        begin
            return 0;
        end
        if (sel < 95)
        begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(30, 8);
    endfunction

    // Transfer one pixel after an optional gap
    task automatic send_pixel(sample_t r, sample_t g, sample_t b, sample_t a);
        int   gap;
        logic was_busy;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        red_in <= r;
        green_in <= g;
        blue_in <= b;
        alpha_in <= a;
        do
        begin
            was_busy = busy;
            @(posedge clk);
        end
        while (was_busy);
    endtask

    // Drain, hold off for the pipeline, then write the bit depth
    task automatic write_depth(depth_t d);
        start <= 1'b0;
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (6) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= d;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic sample_t rand_sample();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5)
        begin
            return sample_t'($urandom);
        end
        if (sel < 8)
        begin
            return sample_t'($urandom_range(1023));
        end
        return (sel == 8) ? 16'hFFFF : 16'h0000;
    endfunction

    // Extremes at reset depth and at the clamped and overflow corners
    task automatic test_directed();
        send_pixel(16'h0000, 16'h03FF, 16'hFFFF, 16'h0001);
        send_pixel(16'h0200, 16'h0155, 16'h02AA, 16'h0400);
        write_depth(5'd1);
        send_pixel(16'hFFFF, 16'hFFEF, 16'hFFF0, 16'h0001);
        send_pixel(16'h0000, 16'h0002, 16'h8000, 16'h7FFF);
        write_depth(5'd0);
        send_pixel(16'hFFFF, 16'h0001, 16'h0000, 16'hFFEF);
        write_depth(5'd16);
        send_pixel(16'h0000, 16'h0001, 16'hFFFF, 16'h8000);
        send_pixel(16'h0002, 16'h0003, 16'h7FFF, 16'hFFFE);
        write_depth(5'd31);
        send_pixel(16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA);
        write_depth(5'd17);
        send_pixel(16'h0001, 16'hFFFF, 16'h0000, 16'h1234);
        write_depth(5'd8);
        send_pixel(16'h00FF, 16'h0080, 16'h0001, 16'h0100);
        send_pixel(16'hFFFF, 16'h007F, 16'h0000, 16'h00FE);
    endtask

    // Each bit depth in turn with a handful of pixels
    task automatic test_depth_sweep();
        for (int d = 0; d < 32; d++)
        begin
            write_depth(depth_t'(d));
            repeat (6) send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        end
    endtask

    // Long random stream with occasional depth changes
    task automatic test_random();
        depth_t d;
        for (int i = 0; i < 1450; i++)
        begin
            if (i % 150 == 0)
            begin
                d = ($urandom_range(3) == 0) ? depth_t'($urandom) :
                    depth_t'($urandom_range(16, 1));
                write_depth(d);
            end
            send_pixel(rand_sample(), rand_sample(), rand_sample(), rand_sample());
        end
        start <= 1'b0;
    endtask

    initial
    begin
        mismatch_count = 0;
        orphan_count = 0;
        model_depth = DEPTH_RESET;
        rst_n = 1'b0;
        start = 1'b0;
        red_in = '0;
        green_in = '0;
        blue_in = '0;
        alpha_in = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_depth_sweep();
        test_random();
        @(posedge clk);
        while (expected_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && orphan_count == 0 && expected_pixels.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #2ms;
        $display("FAIL");
        $finish;
    end
endmodule
